[rtl/assert_macros.svh]
// Assertion macros used by the deframer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/tmd_pkg.sv]
// Shared types and constants for the typed message deframer.
package tmd_pkg;

  localparam int LengthBits  = 16;
  localparam int CountBits   = 17;
  localparam int NumTypes    = 256;
  localparam int TypeBits    = $clog2(NumTypes);
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);

  localparam logic [CountBits-1:0] TlvHeader = CountBits'(3);

  typedef enum logic {
    FuncData    = 1'b0,
    FuncTableWr = 1'b1
  } func_e;

  typedef struct packed {
    logic [7:0]            data;
    logic [LengthBits-1:0] len;
  } tmd_op_t;

endpackage

[rtl/typed_message_deframer_core.sv]
// Top level of the typed message deframer.
//
//  channel  | handshake     | payload
//  ---------+---------------+------------------------------------------------
//  input    | push / full   | func_i, data_byte_i, entry_type_i, entry_length_i
//  result   | empty / pop   | msg_type_o, out_byte_o, byte_offset_o,
//           |               | total_length_o, is_last_o
//
//  One beat per cycle in and out while full stays low and results are popped; a data byte
//  passes the lookup stage, the queue write and the result register. Table writes give no result.
//  The length table lookup is one registered read of the 256-entry table.
//  Reset clears the table valid bits (every type reads as TLV) and parser state.
//  Result stalls fill the 4-entry queue, then the lookup stage, then full rises.
module typed_message_deframer_core
  import tmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  entry_type_i,
  input  logic [15:0] entry_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  out_byte_o,
  output logic [16:0] byte_offset_o,
  output logic [16:0] total_length_o,
  output logic        is_last_o
);

  logic    op_valid, op_full, op_empty, op_pop;
  tmd_op_t op_in, op_out;

  tmd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .entry_type_i   (entry_type_i),
    .entry_length_i (entry_length_i),
    .op_valid_o     (op_valid),
    .op_o           (op_in),
    .op_full_i      (op_full)
  );

  tmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (op_valid),
    .wdata_i (op_in),
    .full_o  (op_full),
    .rd_i    (op_pop),
    .rdata_o (op_out),
    .empty_o (op_empty)
  );

  tmd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_out),
    .op_empty_i     (op_empty),
    .op_pop_o       (op_pop),
    .empty          (empty),
    .pop            (pop),
    .msg_type_o     (msg_type_o),
    .out_byte_o     (out_byte_o),
    .byte_offset_o  (byte_offset_o),
    .total_length_o (total_length_o),
    .is_last_o      (is_last_o)
  );

endmodule

[rtl/tmd_front.sv]
// Front end: input beat capture, length table, lookup stage.
module tmd_front
  import tmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  func_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            entry_type_i,
  input  logic [15:0]           entry_length_i,
  output logic                  op_valid_o,
  output tmd_op_t               op_o,
  input  logic                  op_full_i
);

  logic [LengthBits-1:0] mem_q [NumTypes];
  logic [NumTypes-1:0]   vld_q;
  logic                  stg_valid_q, stg_valid_d;
  logic [7:0]            stg_byte_q;
  logic [LengthBits-1:0] rd_q;
  logic                  rd_vld_q;
  logic                  accept, acc_data, acc_wr, advance;
  logic [TypeBits-1:0]   wr_idx, rd_idx;

  assign advance  = stg_valid_q && !op_full_i;
  assign full     = stg_valid_q && op_full_i;
  assign accept   = push && !full;
  assign acc_data = accept && (func_e'(func_i) == FuncData);
  assign acc_wr   = accept && (func_e'(func_i) == FuncTableWr) && (entry_type_i != 8'd0);
  assign wr_idx   = TypeBits'(entry_type_i);
  assign rd_idx   = TypeBits'(data_byte_i);

  assign stg_valid_d = acc_data || (stg_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      if (acc_wr) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_wr) begin
      mem_q[wr_idx] <= entry_length_i[LengthBits-1:0];
    end
    if (acc_data) begin
      rd_q       <= mem_q[rd_idx];
      rd_vld_q   <= vld_q[rd_idx];
      stg_byte_q <= data_byte_i;
    end
  end

  assign op_valid_o = stg_valid_q;
  assign op_o.data  = stg_byte_q;
  assign op_o.len   = rd_vld_q ? rd_q : '0;

endmodule

[rtl/tmd_fifo.sv]
// Small queue between the lookup front end and the parser.
module tmd_fifo
  import tmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  tmd_op_t wdata_i,
  output logic    full_o,
  input  logic    rd_i,
  output tmd_op_t rdata_o,
  output logic    empty_o
);

  tmd_op_t                mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wptr_q, rptr_q;
  logic [FifoPtrBits:0]   cnt_q;
  logic                   do_wr, do_rd;

  assign full_o  = (cnt_q == (FifoPtrBits+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/tmd_back.sv]
// Back end: message parser and result register.
`include "assert_macros.svh"
module tmd_back
  import tmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmd_op_t              op_i,
  input  logic                 op_empty_i,
  output logic                 op_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           msg_type_o,
  output logic [7:0]           out_byte_o,
  output logic [CountBits-1:0] byte_offset_o,
  output logic [CountBits-1:0] total_length_o,
  output logic                 is_last_o
);

  typedef enum logic [1:0] {
    PhType  = 2'd0,
    PhLenHi = 2'd1,
    PhLenLo = 2'd2,
    PhBody  = 2'd3
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [7:0]           type_q, type_d;
  logic [CountBits-1:0] exp_q, exp_d;
  logic [CountBits-1:0] off_q, off_d;
  logic [7:0]           hi_q, hi_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           res_type, res_byte;
  logic [CountBits-1:0] res_off, res_total;
  logic                 res_last;
  logic                 take;
  logic [CountBits-1:0] lut_len, tlv_len;
  logic [CountBits:0]   off_inc;

  assign take     = !op_empty_i && (!out_valid_q || pop);
  assign op_pop_o = take;
  assign empty    = !out_valid_q;

  assign lut_len = CountBits'(op_i.len);
  assign tlv_len = {1'b0, hi_q, op_i.data} + TlvHeader;
  assign off_inc = {1'b0, off_q} + (CountBits+1)'(1);

  assign out_valid_d = take || (out_valid_q && !pop);

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    exp_d     = exp_q;
    off_d     = off_q;
    hi_d      = hi_q;
    res_type  = type_q;
    res_byte  = op_i.data;
    res_off   = off_q;
    res_total = exp_q;
    res_last  = 1'b0;
    unique case (phase_q)
      PhType: begin
        type_d    = op_i.data;
        res_type  = op_i.data;
        exp_d     = lut_len;
        res_off   = '0;
        res_total = lut_len;
        off_d     = CountBits'(1);
        if (lut_len == '0) begin
          phase_d = PhLenHi;
        end else begin
          res_last = (lut_len == CountBits'(1));
          phase_d  = res_last ? PhType : PhBody;
        end
      end
      PhLenHi: begin
        hi_d      = op_i.data;
        res_off   = CountBits'(1);
        res_total = '0;
        off_d     = CountBits'(2);
        phase_d   = PhLenLo;
      end
      PhLenLo: begin
        exp_d     = tlv_len;
        res_off   = CountBits'(2);
        res_total = tlv_len;
        res_last  = (tlv_len == TlvHeader);
        off_d     = CountBits'(3);
        phase_d   = res_last ? PhType : PhBody;
      end
      PhBody: begin
        res_last = (off_inc >= {1'b0, exp_q});
        off_d    = off_inc[CountBits-1:0];
        if (res_last) begin
          phase_d = PhType;
        end
      end
      default: begin
        phase_d = PhType;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhType;
      type_q      <= '0;
      exp_q       <= '0;
      off_q       <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q        <= phase_d;
        type_q         <= type_d;
        exp_q          <= exp_d;
        off_q          <= off_d;
        hi_q           <= hi_d;
        msg_type_o     <= res_type;
        out_byte_o     <= res_byte;
        byte_offset_o  <= res_off;
        total_length_o <= res_total;
        is_last_o      <= res_last;
      end
    end
  end

  `ASSERT_NEVER(a_last_no_len, clk_i, rst_ni, out_valid_q && is_last_o && (total_length_o == '0))
  `ASSERT_CHK(a_off_in_msg, clk_i, rst_ni, (out_valid_q && (total_length_o != '0)) |-> (byte_offset_o < total_length_o))
  `ASSERT_CHK(a_type_byte, clk_i, rst_ni, (out_valid_q && (byte_offset_o == '0)) |-> (msg_type_o == out_byte_o))

endmodule
